// ===== rtl/pdr_pkg.sv =====
// shared types and constants of the planar delta to rgba decoder
package pdr_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned SIDE_W = 9;
  localparam int unsigned PROD_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 2'd1;

  localparam logic [SIDE_W-1:0] SIDE_MAX = 9'd256;
  localparam logic [SIDE_W-1:0] SIDE_MIN = 9'd1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 2;

  typedef enum logic [1:0] {
    PLANE_RED    = 2'd0,
    PLANE_GREEN  = 2'd1,
    PLANE_BLUE   = 2'd2,
    PLANE_UNUSED = 2'd3
  } plane_e;

  typedef struct packed {
    logic       wr_red;
    logic       wr_green;
    logic       rd;
    logic       last;
    logic [7:0] value;
  } pdr_op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       chunk_end;
  } pdr_pix_t;

endpackage

// ===== rtl/pdr_core.sv =====
// plane and position counters, running delta sum and store control
module pdr_core import pdr_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF,
  parameter int unsigned AddrW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  output pdr_op_t               op_o,
  output logic [AddrW-1:0]      addr_o
);

  localparam int unsigned NeedW = $clog2(MaxPixels + 1);
  localparam int unsigned SizeW = (NeedW > PROD_W) ? NeedW : PROD_W;

  logic [SIDE_W-1:0] width_q, height_q;
  logic [SIDE_W-1:0] side_w, side_h;
  logic [7:0]        running_q, value;
  logic [AddrW-1:0]  pos_q, pos;
  plane_e            plane_q, plane;
  logic [SizeW-1:0]  prod, size, pos_inc;
  logic              last;

  always_comb begin
    side_w = (width_q == '0) ? SIDE_MIN : ((width_q > SIDE_MAX) ? SIDE_MAX : width_q);
    side_h = (height_q == '0) ? SIDE_MIN : ((height_q > SIDE_MAX) ? SIDE_MAX : height_q);
    prod = SizeW'(side_w) * SizeW'(side_h);
    size = (prod > SizeW'(MaxPixels)) ? SizeW'(MaxPixels) : prod;
    pos = (SizeW'(pos_q) >= size) ? '0 : pos_q;
    plane = (plane_q == PLANE_UNUSED) ? PLANE_RED : plane_q;
    value = (pos == '0) ? byte_i : running_q + byte_i;
    pos_inc = SizeW'(pos) + SizeW'(1);
    last = (pos_inc == size);
  end

  always_comb begin
    op_o.wr_red = accept_i && (plane == PLANE_RED);
    op_o.wr_green = accept_i && (plane == PLANE_GREEN);
    op_o.rd = accept_i && (plane == PLANE_BLUE);
    op_o.last = last;
    op_o.value = value;
    addr_o = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= SIDE_MAX;
      height_q <= SIDE_MAX;
      running_q <= '0;
      pos_q <= '0;
      plane_q <= PLANE_RED;
    end else if (cfg_valid_i &&
                 (cfg_index_i == CFG_TILE_WIDTH || cfg_index_i == CFG_TILE_HEIGHT)) begin
      if (cfg_index_i == CFG_TILE_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        height_q <= cfg_data_i;
      end
      running_q <= '0;
      pos_q <= '0;
      plane_q <= PLANE_RED;
    end else if (accept_i) begin
      running_q <= value;
      if (last) begin
        pos_q <= '0;
        plane_q <= (plane == PLANE_BLUE) ? PLANE_RED : plane_e'(plane + 2'd1);
      end else begin
        pos_q <= pos_inc[AddrW-1:0];
      end
    end
  end

endmodule

// ===== rtl/pdr_plane_store.sv =====
// per pixel store of one decoded plane with registered read
module pdr_plane_store import pdr_pkg::*; #(
  parameter int unsigned Depth = MAX_PIXELS_DEF,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pdr_out_fifo.sv =====
// three entry result queue in front of the output port
module pdr_out_fifo import pdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pdr_pix_t             push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output pdr_pix_t             data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  pdr_pix_t               buf_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0]   count_q;

  function automatic logic [OUT_PTR_W-1:0] ptr_next(input logic [OUT_PTR_W-1:0] p);
    ptr_next = (p == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : p + OUT_PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + OUT_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - OUT_CNT_W'(1);
      end
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o = buf_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== rtl/planar_delta_to_rgba_decoder_top.sv =====
// top level of the planar delta to rgba decoder
// a pixel's plane reads and blue byte are registered when its blue byte transfers, then pushed into the output queue
// throughput: one coded byte per cycle while the input is not stalled, red and green bytes give no result
// input stalls while three pixels sit in the queue or in flight to it
// reset: asynchronous, clears counters and queue, tile size returns to 256 by 256
// plane stores are not cleared, an entry is read only after it was written
module planar_delta_to_rgba_decoder_top import pdr_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            coded_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic [7:0]            alpha_o,
  output logic                  chunk_end_o
);

  localparam int unsigned AddrW = (MaxPixels > 1) ? $clog2(MaxPixels) : 1;

  pdr_op_t              op;
  logic [AddrW-1:0]     addr;
  logic                 accept;
  logic                 s1_valid_q;
  logic [7:0]           blue_q;
  logic                 end_q;
  logic [7:0]           red_rd, green_rd;
  pdr_pix_t             push_data, head;
  logic                 pop;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W:0]   pending;

  assign pending = {1'b0, count} + {{OUT_CNT_W{1'b0}}, s1_valid_q};
  assign in_stall_o = (pending >= (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  pdr_core #(
    .MaxPixels (MaxPixels),
    .AddrW     (AddrW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (coded_byte_i),
    .op_o        (op),
    .addr_o      (addr)
  );

  pdr_plane_store #(
    .Depth (MaxPixels),
    .AddrW (AddrW)
  ) u_red_store (
    .clk_i   (clk_i),
    .we_i    (op.wr_red),
    .re_i    (op.rd),
    .addr_i  (addr),
    .wdata_i (op.value),
    .rdata_o (red_rd)
  );

  pdr_plane_store #(
    .Depth (MaxPixels),
    .AddrW (AddrW)
  ) u_green_store (
    .clk_i   (clk_i),
    .we_i    (op.wr_green),
    .re_i    (op.rd),
    .addr_i  (addr),
    .wdata_i (op.value),
    .rdata_o (green_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= op.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op.rd) begin
      blue_q <= op.value;
      end_q <= op.last;
    end
  end

  always_comb begin
    push_data.red = red_rd;
    push_data.green = green_rd;
    push_data.blue = blue_q;
    push_data.chunk_end = end_q;
  end

  assign pop = out_valid_o && !out_stall_i;

  pdr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (count)
  );

  assign red_o = head.red;
  assign green_o = head.green;
  assign blue_o = head.blue;
  assign alpha_o = ALPHA_OPAQUE;
  assign chunk_end_o = head.chunk_end;

endmodule

// ===== rtl/pdr_checker.sv =====
// port level checks of the decoder top, bound to it
module pdr_checker import pdr_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [7:0]            red_o,
  input logic [7:0]            green_o,
  input logic [7:0]            blue_o,
  input logic [7:0]            alpha_o,
  input logic                  chunk_end_o
);

  // backpressure only comes from pixels waiting at the output
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pixel waiting");

  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (alpha_o == ALPHA_OPAQUE))
    else $error("alpha not opaque");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) &&
      $stable(blue_o) && $stable(chunk_end_o))
    else $error("output payload changed while stalled");

endmodule

bind planar_delta_to_rgba_decoder_top pdr_checker u_pdr_checker (.*);
